// File: src/swsr_pkg.sv
package swsr_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW_US      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_US        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANSWER_SAMPLE_US  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANSWER_CONFIRM_US = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_SAMPLE_US     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_FRAME   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_US        = 3'd6;

    // Register reset values
    localparam logic [14:0] RST_START_LOW_US      = 15'd18000;
    localparam logic [7:0]  RST_RELEASE_US        = 8'd20;
    localparam logic [7:0]  RST_ANSWER_SAMPLE_US  = 8'd40;
    localparam logic [7:0]  RST_ANSWER_CONFIRM_US = 8'd20;
    localparam logic [7:0]  RST_BIT_SAMPLE_US     = 8'd40;
    localparam logic [3:0]  RST_BYTES_PER_FRAME   = 4'd5;
    localparam logic [15:0] RST_TIMEOUT_US        = 16'd200;

    localparam logic [3:0]  MAX_BYTES = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ANSWER = 2'd1;
    localparam logic [1:0] ST_TIMEOUT   = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_LOW = 4'd1,
        PH_RELEASE   = 4'd2,
        PH_ANS_LOW   = 4'd3,
        PH_ANS_HIGH  = 4'd4,
        PH_ANS_END   = 4'd5,
        PH_BIT_RISE  = 4'd6,
        PH_BIT_DELAY = 4'd7,
        PH_BIT_FALL  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [14:0] start_low_us;
        logic [7:0]  release_us;
        logic [7:0]  answer_sample_us;
        logic [7:0]  answer_confirm_us;
        logic [7:0]  bit_sample_us;
        logic [3:0]  bytes_per_frame;
        logic [15:0] timeout_us;
    } t_cfg;

    typedef struct packed {
        logic start_req;
        logic line_level;
        logic us_tick;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [2:0] byte_number;
        logic       frame_last;
        logic [1:0] status;
    } t_out_item;

endpackage

// File: src/single_wire_sensor_reader_top.sv
// Channel   Direction  Handshake            Payload
// in        sink       i_in_valid/o_in_stall   i_in_item  (start_req, line_level, us_tick)
// out       source     o_out_valid/i_out_stall o_out_item (drive_low .. status)
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_stall is low; each item passes an input
// register and then the result register before its result is presented.
// The phase state machine and microsecond counter advance once per item.
// Synchronous active-low reset clears control state and loads register defaults.
// A stalled result holds; the input register then fills and o_in_stall rises.
module single_wire_sensor_reader_top #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  swsr_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output swsr_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import swsr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      fire;
    logic      accept_in;
    t_cfg      cfg;
    t_out_item result;

    assign o_cfg_ready = 1'b1;

    swsr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Move an item forward when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept_in  = i_in_valid && !o_in_stall;

    swsr_fsm #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: src/swsr_cfg_regs.sv
module swsr_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]  i_data,
    output swsr_pkg::t_cfg                 o_cfg
);
    import swsr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the index and update the addressed field
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                CFG_START_LOW_US:      n_cfg.start_low_us      = i_data[14:0];
                CFG_RELEASE_US:        n_cfg.release_us        = i_data[7:0];
                CFG_ANSWER_SAMPLE_US:  n_cfg.answer_sample_us  = i_data[7:0];
                CFG_ANSWER_CONFIRM_US: n_cfg.answer_confirm_us = i_data[7:0];
                CFG_BIT_SAMPLE_US:     n_cfg.bit_sample_us     = i_data[7:0];
                CFG_BYTES_PER_FRAME:   n_cfg.bytes_per_frame   = i_data[3:0];
                CFG_TIMEOUT_US:        n_cfg.timeout_us        = i_data[15:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_us      <= RST_START_LOW_US;
            r_cfg.release_us        <= RST_RELEASE_US;
            r_cfg.answer_sample_us  <= RST_ANSWER_SAMPLE_US;
            r_cfg.answer_confirm_us <= RST_ANSWER_CONFIRM_US;
            r_cfg.bit_sample_us     <= RST_BIT_SAMPLE_US;
            r_cfg.bytes_per_frame   <= RST_BYTES_PER_FRAME;
            r_cfg.timeout_us        <= RST_TIMEOUT_US;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/swsr_fsm.sv
module swsr_fsm #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  swsr_pkg::t_in_item  i_item,
    input  swsr_pkg::t_cfg      i_cfg,
    output swsr_pkg::t_out_item o_result
);
    import swsr_pkg::*;

    localparam int CmpW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    t_phase                  r_phase,  n_phase;
    logic [COUNTER_BITS-1:0] r_count,  n_count;
    logic [7:0]              r_shift,  n_shift;
    logic [2:0]              r_bits,   n_bits;
    logic [2:0]              r_bytes,  n_bytes;

    logic                    cnt_sat;
    logic [COUNTER_BITS-1:0] cnt_nxt;
    logic [CmpW-1:0]         target;
    logic                    reached;
    logic [2:0]              last_idx;
    logic                    is_last;
    logic                    want_level;

    // Saturating microsecond counter and target compare
    assign cnt_sat = (r_count == {COUNTER_BITS{1'b1}});
    assign cnt_nxt = r_count + COUNTER_BITS'(i_item.us_tick && !cnt_sat);

    always_comb begin
        case (r_phase)
            PH_START_LOW: target = CmpW'(i_cfg.start_low_us);
            PH_RELEASE:   target = CmpW'(i_cfg.release_us);
            PH_ANS_LOW:   target = CmpW'(i_cfg.answer_sample_us);
            PH_ANS_HIGH:  target = CmpW'(i_cfg.answer_confirm_us);
            PH_BIT_DELAY: target = CmpW'(i_cfg.bit_sample_us);
            default:      target = CmpW'(i_cfg.timeout_us);
        endcase
    end

    assign reached = (CmpW'(cnt_nxt) >= target) || (cnt_nxt == {COUNTER_BITS{1'b1}});

    // Clamp frame length to one through eight bytes
    always_comb begin
        if (i_cfg.bytes_per_frame == 4'd0) begin
            last_idx = 3'd0;
        end else if (i_cfg.bytes_per_frame > MAX_BYTES) begin
            last_idx = 3'd7;
        end else begin
            last_idx = 3'(i_cfg.bytes_per_frame - 4'd1);
        end
    end

    assign is_last    = (r_bytes == last_idx);
    assign want_level = (r_phase == PH_BIT_RISE);

    // Next state and result for the current item
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_bytes  = r_bytes;
        o_result = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase = PH_START_LOW;
                    n_count = '0;
                    n_shift = '0;
                    n_bits  = '0;
                    n_bytes = '0;
                end
            end
            PH_START_LOW, PH_RELEASE: begin
                n_count = cnt_nxt;
                if (reached) begin
                    n_count = '0;
                    n_phase = (r_phase == PH_START_LOW) ? PH_RELEASE : PH_ANS_LOW;
                end
            end
            PH_ANS_LOW: begin
                n_count = cnt_nxt;
                if (reached) begin
                    n_count = '0;
                    if (!i_item.line_level) begin
                        n_phase = PH_ANS_HIGH;
                    end else begin
                        n_phase         = PH_IDLE;
                        o_result.status = ST_NO_ANSWER;
                    end
                end
            end
            PH_ANS_HIGH: begin
                n_count = cnt_nxt;
                if (reached) begin
                    n_count = '0;
                    if (i_item.line_level) begin
                        n_phase = PH_ANS_END;
                    end else begin
                        n_phase         = PH_IDLE;
                        o_result.status = ST_NO_ANSWER;
                    end
                end
            end
            PH_ANS_END, PH_BIT_RISE, PH_BIT_FALL: begin
                if (i_item.line_level == want_level) begin
                    n_count = '0;
                    if (r_phase == PH_ANS_END) begin
                        n_phase = PH_BIT_RISE;
                    end else if (r_phase == PH_BIT_RISE) begin
                        n_phase = PH_BIT_DELAY;
                    end else if (r_bits != 3'd0) begin
                        n_phase = PH_BIT_RISE;
                    end else begin
                        // Present the finished byte
                        o_result.byte_valid  = 1'b1;
                        o_result.byte_value  = r_shift;
                        o_result.byte_number = r_bytes;
                        o_result.frame_last  = is_last;
                        n_shift              = '0;
                        if (is_last) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_bytes = r_bytes + 3'd1;
                            n_phase = PH_BIT_RISE;
                        end
                    end
                end else begin
                    n_count = cnt_nxt;
                    if (reached) begin
                        n_count         = '0;
                        n_phase         = PH_IDLE;
                        o_result.status = ST_TIMEOUT;
                    end
                end
            end
            PH_BIT_DELAY: begin
                n_count = cnt_nxt;
                if (reached) begin
                    n_count = '0;
                    n_shift = {r_shift[6:0], i_item.line_level};
                    n_bits  = r_bits + 3'd1;
                    n_phase = PH_BIT_FALL;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_count = '0;
            end
        endcase

        o_result.drive_low = (n_phase == PH_START_LOW);
        o_result.busy_res  = (n_phase != PH_IDLE);
    end

    // Advance state only when an item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_bytes <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_bytes <= n_bytes;
        end
    end

endmodule
